@@ rtl/k_way_sorted_list_merge_top_assert.svh @@
// Assertion macros shared by the merge block modules.
`ifndef K_WAY_SORTED_LIST_MERGE_TOP_ASSERT_SVH
`define K_WAY_SORTED_LIST_MERGE_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define KWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define KWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/kwm_pkg.sv @@
// Shared constants, codes and types of the k-way merge block.
package kwm_pkg;

    localparam int LISTS     = 8;
    localparam int DEPTH     = 256;
    localparam int LIST_W    = $clog2(LISTS);
    localparam int POS_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ADDR_W    = LIST_W + POS_W;
    localparam int MEM_WORDS = 1 << ADDR_W;

    localparam int OP_W     = 2;
    localparam int ID_W     = 3;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 3;
    localparam int SPOS_W   = 8;
    localparam int IN_TD_W  = 40;
    localparam int OUT_TD_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_POPPED    = 3'd0,
        ST_APPENDED  = 3'd1,
        ST_CLEARED   = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // One head read in flight: lines up with the registered memory data.
    typedef struct packed {
        logic              valid;
        logic              live;
        logic [LIST_W-1:0] list;
    } head_t;

    // Running minimum of the scan.
    typedef struct packed {
        logic              found;
        logic [LIST_W-1:0] list;
        logic [VAL_W-1:0]  value;
    } best_t;

endpackage

@@ rtl/kwm_store.sv @@
// Element store: one write port, one read port with registered read data.
module kwm_store (
    input  logic                      clk,
    input  logic                      we,
    input  logic [kwm_pkg::ADDR_W-1:0] waddr,
    input  logic [kwm_pkg::VAL_W-1:0]  wdata,
    input  logic                      re,
    input  logic [kwm_pkg::ADDR_W-1:0] raddr,
    output logic [kwm_pkg::VAL_W-1:0]  rdata
);
    import kwm_pkg::*;

    logic [VAL_W-1:0] mem [MEM_WORDS];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/kwm_scan.sv @@
// Min-select over list heads, one head per cycle, ties kept by the lower list.
`include "k_way_sorted_list_merge_top_assert.svh"

module kwm_scan (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  kwm_pkg::head_t           head,
    input  logic [kwm_pkg::VAL_W-1:0] rd_data,
    output kwm_pkg::best_t           best
);
    import kwm_pkg::*;

    logic              found_reg;
    logic [LIST_W-1:0] list_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              take;

    // Strict less-than keeps the earlier (lower) list on a tie.
    always_comb
    begin
        take = head.valid && head.live &&
               (!found_reg || ($signed(rd_data) < $signed(value_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !start)
        begin
            list_reg  <= head.list;
            value_reg <= rd_data;
        end
    end

    assign best = '{found: found_reg, list: list_reg, value: value_reg};

    `KWM_ASSERT(a_start_clears, start |=> !found_reg, "scan start did not clear best")
    `KWM_ASSERT(a_found_drop, $fell(found_reg) |-> $past(start), "best lost without start")
    `KWM_ASSERT(a_take_live, (take && !start) |=> found_reg, "accepted head not recorded")

endmodule

@@ rtl/k_way_sorted_list_merge_top.sv @@
// Top level of the k-way sorted list merge block.
//
// Usage: one command per transaction on the s_axis channel. tuser holds the
// opcode (clear all lists, append value to list_id, pop minimum); tdata holds
// list_id and value. Each command gives exactly one response on m_axis: tuser
// is the status, tdata carries the popped value, its list and its position.
// Clear and append go straight from acceptance to the response state. A pop
// reads the head of every list from the element store, one list per cycle
// through the single read port, then waits for the last head to arrive.
// Commands are handled one at a time; s_axis_tready is high whenever no
// command is in progress, even while a response waits in the output register.
// Reset clears every fill count and read pointer, so all lists start empty;
// the element store itself is not cleared and needs no clearing pass.
// If the receiver stalls, the response holds in the output register and the
// next command completes only once that register drains.
`include "k_way_sorted_list_merge_top_assert.svh"

module k_way_sorted_list_merge_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [2:0] list_id, [34:3] value, [39:35] zero
    input  logic [kwm_pkg::IN_TD_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [kwm_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [31:0] out_value, [34:32] src_list, [42:35] src_position, [47:43] zero
    output logic [kwm_pkg::OUT_TD_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [kwm_pkg::ST_W-1:0]     m_axis_tuser
);
    import kwm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg;
    logic [ID_W-1:0]   lid_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  fill_reg [LISTS];
    logic [CNT_W-1:0]  rp_reg [LISTS];
    logic [LIST_W-1:0] scan_idx_reg;
    head_t             head_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [ID_W-1:0]   out_list_reg;
    logic [SPOS_W-1:0] out_pos_reg;

    logic              in_fire;
    logic              resp_fire;
    logic              scan_last;
    logic [LIST_W-1:0] lid_idx;
    logic              append_ok;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_re;
    logic [VAL_W-1:0]  mem_rdata;
    best_t             best;
    status_t           resp_status;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    // Commit a response only when the output register is free or draining.
    assign resp_fire     = (state_reg == S_RESP) && (!out_valid_reg || m_axis_tready);
    assign scan_last     = (scan_idx_reg == LIST_W'(LISTS - 1));

    // Append target and its room check; list numbers past LISTS count as full.
    assign lid_idx   = LIST_W'(lid_reg);
    assign append_ok = (32'(lid_reg) < LISTS) && (fill_reg[lid_idx] < CNT_W'(DEPTH));

    assign mem_we    = resp_fire && (op_reg == OP_APPEND) && append_ok;
    assign mem_waddr = {lid_idx, fill_reg[lid_idx][POS_W-1:0]};
    assign mem_re    = (state_reg == S_SCAN);
    assign mem_raddr = {scan_idx_reg, rp_reg[scan_idx_reg][POS_W-1:0]};

    kwm_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (val_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    kwm_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_fire),
        .head    (head_reg),
        .rd_data (mem_rdata),
        .best    (best)
    );

    // Sequencer: a pop sweeps all lists, then waits in S_DRAIN for the last head.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (op_t'(s_axis_tuser) == OP_POP) ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (resp_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the command payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= op_t'(s_axis_tuser);
            lid_reg <= s_axis_tdata[ID_W-1:0];
            val_reg <= s_axis_tdata[ID_W+VAL_W-1:ID_W];
        end
    end

    // Advance the scan index and tag each head read with its list and liveness.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            head_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                scan_idx_reg <= '0;
            end
            else if (mem_re && !scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + LIST_W'(1);
            end
            head_reg.valid <= mem_re;
            head_reg.live  <= rp_reg[scan_idx_reg] < fill_reg[scan_idx_reg];
            head_reg.list  <= scan_idx_reg;
        end
    end

    // Fill counts and read pointers: cleared, bumped by append or by pop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LISTS; i++)
            begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
            end
        end
        else if (resp_fire)
        begin
            case (op_reg)
                OP_CLEAR:
                begin
                    for (int i = 0; i < LISTS; i++)
                    begin
                        fill_reg[i] <= '0;
                        rp_reg[i]   <= '0;
                    end
                end
                OP_APPEND:
                begin
                    if (append_ok)
                    begin
                        fill_reg[lid_idx] <= fill_reg[lid_idx] + CNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (best.found)
                    begin
                        rp_reg[best.list] <= rp_reg[best.list] + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_CLEAR:  resp_status = ST_CLEARED;
            OP_APPEND: resp_status = append_ok ? ST_APPENDED : ST_FULL;
            OP_POP:    resp_status = best.found ? ST_POPPED : ST_EXHAUSTED;
            default:   resp_status = ST_EXHAUSTED;
        endcase
    end

    // Output register: load on commit, drop when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (resp_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_fire)
        begin
            out_status_reg <= resp_status;
            if (resp_status == ST_POPPED)
            begin
                out_value_reg <= best.value;
                out_list_reg  <= ID_W'(best.list);
                out_pos_reg   <= SPOS_W'(rp_reg[best.list]);
            end
            else
            begin
                out_value_reg <= '0;
                out_list_reg  <= '0;
                out_pos_reg   <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {(OUT_TD_W - VAL_W - ID_W - SPOS_W)'(0),
                            out_pos_reg, out_list_reg, out_value_reg};

    `KWM_ASSERT(a_we_in_resp, mem_we |-> (state_reg == S_RESP), "store written outside commit")
    `KWM_ASSERT(a_busy_after_accept, in_fire |=> (state_reg != S_IDLE), "accept left idle")
    `KWM_ASSERT(a_pop_in_range,
        (resp_fire && (op_reg == OP_POP) && best.found)
            |-> (rp_reg[best.list] < fill_reg[best.list]),
        "pop from a list with no unread element")
    `KWM_ASSERT_ALWAYS(a_ready_idle, s_axis_tready |-> !head_reg.valid || !rst_n,
        "head read pending while idle")

endmodule
